// File: sv/pbs_pkg.sv
// Shared types and constants for the packed bit field store.
package pbs_pkg;

    localparam int WORD_W = 64;
    localparam int POS_W  = 16;
    localparam int LEN_W  = 7;
    localparam int OFF_W  = 6;
    localparam int IDX_W  = POS_W - OFF_W;

    localparam logic KIND_READ  = 1'b0;
    localparam logic KIND_WRITE = 1'b1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MOD,
        ST_RD_HI,
        ST_RD_LO,
        ST_CALC,
        ST_WR_LO
    } pbs_state_t;

endpackage

// File: sv/pbs_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module pbs_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: sv/packed_bitfield_store.sv
// Top level of the packed bit field store: sequencer, field datapath and word RAM.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+-----------------------------------------
//   in      | input     | in_valid / in_ready  | kind, bit_position, field_length,
//           |           |                      | write_value
//   out     | output    | out_valid / out_ready| read_value (one per read transaction)
//
// One transaction at a time is worked on, and the single read port of the word RAM sets
// the pace: a read or a write within one word goes from one acceptance to the next
// through idle, two word reads and merge, and a write that straddles two words then
// writes the second word in a state of its own.
// When STORE_WORDS is neither a power of two nor at least 1024, the word index is reduced
// modulo STORE_WORDS by a reciprocal multiply, a multiply back by the depth and one
// compare and subtract, one step per cycle, before the two word reads.
// After reset the block sweeps the RAM to zero, one word per cycle, from word 0 to the
// last word, and holds in_ready low until the sweep is done.
// A finished read result waits in the output register; the next transaction is taken
// meanwhile, and the block only stalls if a second result is ready before the first is
// taken.
module packed_bitfield_store
    import pbs_pkg::*;
#(
    parameter int STORE_WORDS = 1024
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic              kind,
    input  logic [POS_W-1:0]  bit_position,
    input  logic [LEN_W-1:0]  field_length,
    input  logic [WORD_W-1:0] write_value,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [WORD_W-1:0] read_value
);

    localparam int ADDR_W = $clog2(STORE_WORDS);
    localparam int MOD_SH = 20;
    localparam int CNT_W  = 2;
    localparam bit IDX_DIRECT = ((STORE_WORDS & (STORE_WORDS - 1)) == 0)
                                || (STORE_WORDS >= (1 << IDX_W));
    localparam logic [ADDR_W-1:0] LAST_WORD = ADDR_W'(STORE_WORDS - 1);
    localparam logic [CNT_W-1:0]  LAST_STEP = CNT_W'(2);
    // The reciprocal is rounded down, so the quotient estimate is at most one too low
    // and the remainder estimate stays below twice the depth.
    localparam logic [IDX_W+MOD_SH-1:0] RECIP =
        (IDX_W + MOD_SH)'((1 << MOD_SH) / STORE_WORDS);
    localparam logic [IDX_W+ADDR_W-1:0] DEPTH_WIDE = (IDX_W + ADDR_W)'(STORE_WORDS);
    localparam logic [IDX_W-1:0]        DEPTH_IDX  = IDX_W'(STORE_WORDS);

    // Control registers.
    pbs_state_t          state_reg, state_next;
    logic [ADDR_W-1:0]   clr_reg;
    logic [CNT_W-1:0]    step_reg;
    logic                out_valid_reg;

    // Transaction registers.
    logic                kind_reg;
    logic [OFF_W-1:0]    off_reg;
    logic [LEN_W-1:0]    len_reg;
    logic [WORD_W-1:0]   value_reg;
    logic [IDX_W-1:0]    word_reg;
    logic [IDX_W-1:0]    quot_reg;
    logic [IDX_W-1:0]    prod_reg;
    logic [ADDR_W-1:0]   first_reg;
    logic [WORD_W-1:0]   hi_reg;
    logic [WORD_W-1:0]   lo_reg;
    logic [WORD_W-1:0]   read_value_reg;

    // RAM ports.
    logic                ram_we;
    logic [ADDR_W-1:0]   ram_waddr;
    logic [WORD_W-1:0]   ram_wdata;
    logic                ram_re;
    logic [ADDR_W-1:0]   ram_raddr;
    logic [WORD_W-1:0]   ram_rdata;

    // Datapath signals.
    logic                    in_fire;
    logic                    out_load;
    logic [POS_W-1:0]        word_ext;
    logic [ADDR_W-1:0]       direct_idx;
    logic [LEN_W-1:0]        len_sat;
    logic [IDX_W+MOD_SH-1:0] quot_full;
    logic [IDX_W+ADDR_W-1:0] prod_full;
    logic [IDX_W-1:0]        rem_est;
    logic [IDX_W-1:0]        rem_fix;
    logic [ADDR_W-1:0]       second;
    logic                    len_zero;
    logic                    straddle;
    logic [7:0]              sh;
    logic [WORD_W-1:0]       fmask;
    logic [2*WORD_W-1:0]     cat;
    logic [2*WORD_W-1:0]     shifted;
    logic [2*WORD_W-1:0]     m128;
    logic [2*WORD_W-1:0]     v128;
    logic [2*WORD_W-1:0]     merged;
    logic [WORD_W-1:0]       field_rd;

    assign in_ready  = (state_reg == ST_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign read_value = read_value_reg;

    // Word index straight from the bit position; a plain truncation gives the modulo
    // when the depth is a power of two, and nothing wraps when the depth covers 1024 words.
    assign word_ext   = {{OFF_W{1'b0}}, bit_position[POS_W-1:OFF_W]};
    assign direct_idx = word_ext[ADDR_W-1:0];
    assign len_sat    = (field_length > LEN_W'(WORD_W)) ? LEN_W'(WORD_W) : field_length;

    // Remainder by the depth in three registered steps: quotient estimate, product with
    // the depth, then the difference with one correcting subtraction.
    assign quot_full = {{MOD_SH{1'b0}}, word_reg} * RECIP;
    assign prod_full = {{ADDR_W{1'b0}}, quot_reg} * DEPTH_WIDE;
    assign rem_est   = word_reg - prod_reg;
    assign rem_fix   = (rem_est >= DEPTH_IDX) ? rem_est - DEPTH_IDX : rem_est;

    assign second = (first_reg == LAST_WORD) ? '0 : first_reg + 1'b1;

    // The two words form one 128-bit string; the field sits sh bits above its bottom.
    assign len_zero = (len_reg == '0);
    assign straddle = (({1'b0, off_reg} + len_reg) > LEN_W'(WORD_W));
    assign sh       = 8'd128 - {2'b00, off_reg} - {1'b0, len_reg};
    assign fmask    = len_zero ? '0 : ({WORD_W{1'b1}} >> (LEN_W'(WORD_W) - len_reg));
    assign cat      = {hi_reg, ram_rdata};
    assign shifted  = cat >> sh;
    assign field_rd = shifted[WORD_W-1:0] & fmask;
    assign m128     = {{WORD_W{1'b0}}, fmask} << sh;
    assign v128     = {{WORD_W{1'b0}}, value_reg & fmask} << sh;
    assign merged   = (cat & ~m128) | v128;

    always_comb
    begin
        state_next = state_reg;
        ram_we     = 1'b0;
        ram_waddr  = first_reg;
        ram_wdata  = merged[2*WORD_W-1:WORD_W];
        ram_re     = 1'b0;
        ram_raddr  = first_reg;
        out_load   = 1'b0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                ram_wdata = '0;
                if (clr_reg == LAST_WORD)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = IDX_DIRECT ? ST_RD_HI : ST_MOD;
                end
            end
            ST_MOD:
            begin
                if (step_reg == LAST_STEP)
                begin
                    state_next = ST_RD_HI;
                end
            end
            ST_RD_HI:
            begin
                ram_re     = 1'b1;
                state_next = ST_RD_LO;
            end
            ST_RD_LO:
            begin
                ram_re     = 1'b1;
                ram_raddr  = second;
                state_next = ST_CALC;
            end
            ST_CALC:
            begin
                if (kind_reg == KIND_WRITE)
                begin
                    ram_we     = !len_zero;
                    state_next = (straddle && !len_zero) ? ST_WR_LO : ST_IDLE;
                end
                else if (!out_valid_reg || out_ready)
                begin
                    // The previous result is gone or leaves now, so this one may take its place.
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_WR_LO:
            begin
                ram_we     = 1'b1;
                ram_waddr  = second;
                ram_wdata  = lo_reg;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR)
            begin
                clr_reg <= clr_reg + 1'b1;
            end
            if (in_fire)
            begin
                step_reg <= '0;
            end
            else if (state_reg == ST_MOD)
            begin
                step_reg <= step_reg + 1'b1;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            kind_reg  <= kind;
            off_reg   <= bit_position[OFF_W-1:0];
            len_reg   <= len_sat;
            value_reg <= write_value;
            word_reg  <= bit_position[POS_W-1:OFF_W];
            first_reg <= IDX_DIRECT ? direct_idx : '0;
        end
        else if (state_reg == ST_MOD)
        begin
            quot_reg <= quot_full[IDX_W+MOD_SH-1:MOD_SH];
            prod_reg <= prod_full[IDX_W-1:0];
            if (step_reg == LAST_STEP)
            begin
                first_reg <= ADDR_W'(rem_fix);
            end
        end
        if (state_reg == ST_RD_LO)
        begin
            hi_reg <= ram_rdata;
        end
        if (state_reg == ST_CALC)
        begin
            lo_reg <= merged[WORD_W-1:0];
        end
        if (out_load)
        begin
            read_value_reg <= field_rd;
        end
    end

    pbs_ram #(
        .WIDTH (WORD_W),
        .DEPTH (STORE_WORDS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

endmodule

// File: sv/pbs_checker.sv
// Port-level assertions for the packed bit field store and their bind.
module pbs_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [63:0] read_value
);

    // Only one transaction is in flight, so acceptance closes the input at once.
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("input accepted while a transaction is in flight");

    // No result can appear in the cycle right after a transaction is taken.
    a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && !out_valid) |=> !out_valid)
        else $error("result appeared too early after an input transaction");

    // A result that is not taken stays put.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(read_value)))
        else $error("stalled result changed or vanished");

endmodule

bind packed_bitfield_store pbs_checker u_pbs_checker (.*);

// File: tb/tb.sv
// Testbench for the packed bit field store: directed table, then checked random accesses.
`timescale 1ns / 1ps

module tb;
    import pbs_pkg::*;

    // The store is instantiated at its default depth. Because bit_position is 16 bits wide,
    // a field that starts in the last word runs on into word 0.
    localparam int STORE_WORDS = 1024;

    // Timing of the run. The clearing sweep after reset holds in_ready low while it zeroes
    // every word. The receiver hold-off is the longest stretch with no transaction after that
    // sweep. The watchdog limit is set well above both.
    localparam int CLK_HALF         = 6;
    localparam int RESET_CYCLES     = 3;
    localparam int HOLD_CYCLES      = 240;
    localparam int DRAIN_CYCLES     = 16;
    localparam int WATCHDOG_LIMIT   = 4000;
    localparam int RANDOM_PER_PHASE = 375;

    // One row of the directed table. Where has_fixed is set, the read result is typed in
    // by hand. Every other row is checked against the predictor.
    typedef struct packed {
        logic              kind;
        logic [POS_W-1:0]  pos;
        logic [LEN_W-1:0]  len;
        logic [WORD_W-1:0] value;
        logic              has_fixed;
        logic [WORD_W-1:0] fixed_read;
    } access_row_t;

    localparam logic [WORD_W-1:0] ONES = {WORD_W{1'b1}};
    localparam int DIRECTED_ROWS = 25;

    localparam access_row_t DIRECTED [DIRECTED_ROWS] = '{
        // The store must read back as zeros after reset, including a field that wraps.
        '{KIND_READ,  16'd0,     7'd64,  64'd0,                 1'b1, 64'd0},
        '{KIND_READ,  16'hFFFF,  7'd64,  64'd0,                 1'b1, 64'd0},
        // Fill word 0 completely, then read it back whole and across the word boundary.
        '{KIND_WRITE, 16'd0,     7'd64,  ONES,                  1'b0, 64'd0},
        '{KIND_READ,  16'd0,     7'd64,  64'd0,                 1'b1, ONES},
        '{KIND_READ,  16'd60,    7'd8,   64'd0,                 1'b0, 64'd0},
        // Write a field that starts at the last bit of the last word and wraps into word 0.
        '{KIND_WRITE, 16'hFFFF,  7'd64,  64'h8000_0000_0000_0001, 1'b0, 64'd0},
        '{KIND_READ,  16'hFFFF,  7'd64,  64'd0,                 1'b0, 64'd0},
        '{KIND_READ,  16'd0,     7'd64,  64'd0,                 1'b0, 64'd0},
        // A zero-length write changes nothing. A zero-length read still returns a zero.
        '{KIND_WRITE, 16'd100,   7'd0,   ONES,                  1'b0, 64'd0},
        '{KIND_READ,  16'd100,   7'd0,   64'd0,                 1'b1, 64'd0},
        '{KIND_READ,  16'd64,    7'd64,  64'd0,                 1'b0, 64'd0},
        // A length above 64 is saturated to 64, on both writes and reads.
        '{KIND_WRITE, 16'd128,   7'd100, 64'hDEAD_BEEF_0123_4567, 1'b0, 64'd0},
        '{KIND_READ,  16'd128,   7'd127, 64'd0,                 1'b0, 64'd0},
        // Single bits are set and cleared with one-bit writes. The value is wider than
        // the field, so only its low bit may land.
        '{KIND_WRITE, 16'd200,   7'd1,   64'h3,                 1'b0, 64'd0},
        '{KIND_WRITE, 16'd201,   7'd1,   ONES,                  1'b0, 64'd0},
        '{KIND_WRITE, 16'd200,   7'd1,   64'd0,                 1'b0, 64'd0},
        '{KIND_READ,  16'd198,   7'd8,   64'd0,                 1'b0, 64'd0},
        // A wide value is masked to a five-bit field.
        '{KIND_WRITE, 16'd300,   7'd5,   ONES,                  1'b0, 64'd0},
        '{KIND_READ,  16'd296,   7'd16,  64'd0,                 1'b0, 64'd0},
        // A full-length field that straddles words 15 and 16.
        '{KIND_WRITE, 16'd1000,  7'd64,  64'h0123_4567_89AB_CDEF, 1'b0, 64'd0},
        '{KIND_READ,  16'd1000,  7'd64,  64'd0,                 1'b0, 64'd0},
        '{KIND_READ,  16'd1024,  7'd1,   64'd0,                 1'b0, 64'd0},
        // An aligned write of the whole last word.
        '{KIND_WRITE, 16'hFFC0,  7'd64,  64'hA5A5_5A5A_C3C3_3C3C, 1'b0, 64'd0},
        '{KIND_READ,  16'hFFC0,  7'd64,  64'd0,                 1'b0, 64'd0},
        '{KIND_READ,  16'd0,     7'd1,   64'd0,                 1'b0, 64'd0}
    };

    // Every input is driven to a known value from time zero.
    logic              clk          = 1'b0;
    logic              rst_n        = 1'b0;
    logic              in_valid     = 1'b0;
    logic              in_ready;
    logic              kind         = KIND_READ;
    logic [POS_W-1:0]  bit_position = '0;
    logic [LEN_W-1:0]  field_length = '0;
    logic [WORD_W-1:0] write_value  = '0;
    logic              out_valid;
    logic              out_ready    = 1'b0;
    logic [WORD_W-1:0] read_value;

    // This is the testbench's own copy of the store. It is cleared like the block's store.
    logic [WORD_W-1:0] bit_string_copy [STORE_WORDS];
    // These are the read results still owed by the block, oldest first.
    logic [WORD_W-1:0] pending_reads [$];

    int  send_idle_pct = 0;
    int  recv_idle_pct = 0;
    bit  hold_request  = 1'b0;
    int  mismatches    = 0;
    int  reads_sent    = 0;
    int  writes_sent   = 0;
    int  results_seen  = 0;
    int  quiet_cycles  = 0;

    packed_bitfield_store #(
        .STORE_WORDS(STORE_WORDS)
    ) uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .kind        (kind),
        .bit_position(bit_position),
        .field_length(field_length),
        .write_value (write_value),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .read_value  (read_value)
    );

    always #CLK_HALF clk = ~clk;

    initial
    begin
        foreach (bit_string_copy[i])
        begin
            bit_string_copy[i] = '0;
        end
    end

    // This function applies one access to the copy of the store. The two words that the
    // field can touch are joined into one 128-bit window, with the first word on top, so
    // that a straddling field is just a contiguous slice of the window. The function
    // returns 1 when the access produces a read result.
    function automatic bit apply_field_access(input logic k, input logic [POS_W-1:0] pos,
                                              input logic [LEN_W-1:0] len_in,
                                              input logic [WORD_W-1:0] value,
                                              output logic [WORD_W-1:0] field);
        int unsigned  first_word;
        int unsigned  next_word;
        int unsigned  off;
        int unsigned  len;
        int unsigned  lift;
        logic [127:0] window;
        logic [127:0] mask;
        logic [127:0] slice;
        first_word = (int'(pos) >> 6) % STORE_WORDS;
        next_word  = (first_word + 1) % STORE_WORDS;
        off        = int'(pos[5:0]);
        len        = (len_in > 7'd64) ? 64 : int'(len_in);
        window     = {bit_string_copy[first_word], bit_string_copy[next_word]};
        field      = '0;
        if (k == KIND_READ)
        begin
            if (len != 0)
            begin
                slice = (window << off) >> (128 - len);
                field = slice[WORD_W-1:0];
            end
            return 1'b1;
        end
        if (len != 0)
        begin
            // The field's top bit sits at window bit 127 - off.
            lift   = 128 - off - len;
            mask   = ((128'd1 << len) - 128'd1) << lift;
            window = (window & ~mask) | (({64'd0, value} << lift) & mask);
            bit_string_copy[first_word] = window[127:64];
            bit_string_copy[next_word]  = window[63:0];
        end
        return 1'b0;
    endfunction

    task automatic report_mismatch(input string what, input logic [WORD_W-1:0] got,
                                   input logic [WORD_W-1:0] want);
        $display("[%0t] MISMATCH %s: read_value %h, expected %h", $time, what, got, want);
        mismatches++;
    endtask

    // This task offers one transaction and holds it until the block accepts it. The
    // task may insert idle cycles first. The predictor runs at the edge where the
    // transaction is taken.
    task automatic drive_access(input logic k, input logic [POS_W-1:0] pos,
                                input logic [LEN_W-1:0] len, input logic [WORD_W-1:0] value,
                                input logic has_fixed, input logic [WORD_W-1:0] fixed_read);
        logic [WORD_W-1:0] field;
        if ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        in_valid     <= 1'b1;
        kind         <= k;
        bit_position <= pos;
        field_length <= len;
        write_value  <= value;
        do
            @(posedge clk);
        while (!in_ready);
        if (apply_field_access(k, pos, len, value, field))
        begin
            pending_reads.push_back(has_fixed ? fixed_read : field);
        end
        if (k == KIND_READ)
        begin
            reads_sent++;
        end
        else
        begin
            writes_sent++;
        end
    endtask

    // This is the receiver. It checks each result transaction against the oldest
    // outstanding read, then picks out_ready for the next cycle. When asked, it holds
    // out_ready low for a long stretch so that the output register fills and the block
    // has to stall its input.
    initial
    begin : receiver
        int                hold_left;
        logic [WORD_W-1:0] want;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
            begin
                results_seen++;
                if (pending_reads.size() == 0)
                begin
                    report_mismatch("result with no read outstanding", read_value, '0);
                end
                else
                begin
                    want = pending_reads.pop_front();
                    if (read_value !== want)
                    begin
                        report_mismatch("read field", read_value, want);
                    end
                end
            end
            if (hold_request)
            begin
                hold_request = 1'b0;
                hold_left    = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // The watchdog ends the run if nothing moves on either channel for too long.
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("[%0t] watchdog: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("CHECKS FAILED");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // This is the stimulus: reset, the directed table, then three random phases with
    // different idle patterns.
    initial
    begin : stimulus
        logic              k;
        logic [POS_W-1:0]  pos;
        logic [LEN_W-1:0]  len;
        logic [WORD_W-1:0] value;
        logic [POS_W-1:0]  last_pos;
        logic [LEN_W-1:0]  last_len;
        int                pick;

        last_pos = '0;
        last_len = 7'd1;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        send_idle_pct = 8;
        recv_idle_pct = 68;
        foreach (DIRECTED[i])
        begin
            drive_access(DIRECTED[i].kind, DIRECTED[i].pos, DIRECTED[i].len,
                         DIRECTED[i].value, DIRECTED[i].has_fixed, DIRECTED[i].fixed_read);
        end

        for (int phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle_pct = 8;
                    recv_idle_pct = 68;
                end
                1:
                begin
                    send_idle_pct = 68;
                    recv_idle_pct = 8;
                end
                default:
                begin
                    // No idling at all. The long receiver hold-off starts here while the
                    // sender keeps offering transactions back to back.
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                    hold_request  = 1'b1;
                end
            endcase
            repeat (RANDOM_PER_PHASE)
            begin
                k = 1'($urandom_range(1));
                // Half of the positions are drawn from the first sixteen words, so that reads mostly see
                // data that was written. The rest hit word boundaries, the wrap from the
                // last word to word 0, or any position at all.
                pick = $urandom_range(9);
                if (pick < 5)
                begin
                    pos = POS_W'($urandom_range(1023));
                end
                else if (pick < 7)
                begin
                    pos = {10'($urandom_range(1023)), 6'($urandom_range(48, 63))};
                end
                else if (pick < 8)
                begin
                    pos = POS_W'(65535 - $urandom_range(127));
                end
                else
                begin
                    pos = POS_W'($urandom_range(65535));
                end
                // Lengths are mostly legal. Zero and values above 64 appear now and then.
                pick = $urandom_range(15);
                if (pick == 0)
                begin
                    len = '0;
                end
                else if (pick == 1)
                begin
                    len = LEN_W'($urandom_range(65, 127));
                end
                else if (pick == 2)
                begin
                    len = 7'd64;
                end
                else
                begin
                    len = LEN_W'($urandom_range(1, 64));
                end
                value = {$urandom, $urandom};
                // Some reads go back to the field most recently written.
                if (k == KIND_READ && $urandom_range(2) == 0)
                begin
                    pos = last_pos;
                    len = last_len;
                end
                if (k == KIND_WRITE)
                begin
                    last_pos = pos;
                    last_len = len;
                end
                drive_access(k, pos, len, value, 1'b0, '0);
            end
        end

        in_valid <= 1'b0;
        while (pending_reads.size() != 0) @(posedge clk);
        // Allow a few more cycles so that a stray extra result would still be caught.
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Ran %0d reads and %0d writes, %0d results checked; fields straddled words,",
                 reads_sent, writes_sent, results_seen);
        $display("wrapped past the last word, and had zero, saturated and over-wide inputs.");
        if (mismatches == 0)
        begin
            $display("ALL CHECKS PASSED");
        end
        else
        begin
            $display("%0d mismatches", mismatches);
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
